/* rtl/core/lfu_pkg.sv */
// lfu_pkg: shared types and constants for the LFU page replacement table.
// Holds the request/response beats, the cell broadcast and the victim-search token.
// No dependencies.
package lfu_pkg;

	localparam int unsigned KEY_BITS   = 32;
	localparam int unsigned COUNT_BITS = 16;
	localparam int unsigned CAP_BITS   = 5;

	localparam logic [CAP_BITS-1:0]   CAP_RESET = 5'd16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [1:0] ACT_ACCESS = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		UPD_NONE   = 2'd0,
		UPD_RAISE  = 2'd1,
		UPD_REMOVE = 2'd2,
		UPD_INSERT = 2'd3
	} upd_op_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [KEY_BITS-1:0] page_key;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic                  evicted;
		logic [KEY_BITS-1:0]   victim_key;
		logic [COUNT_BITS-1:0] victim_count;
	} rsp_t;

	// Update command seen by every cell in the same cycle
	typedef struct packed {
		upd_op_t             op;
		logic                ev;
		logic [KEY_BITS-1:0] key;
	} bcast_t;

	// Best-victim token handed from cell to cell
	typedef struct packed {
		logic                  vld;
		logic [COUNT_BITS-1:0] cnt;
		logic [KEY_BITS-1:0]   key;
		logic                  free_found;
	} cand_t;

	typedef struct packed {
		logic match;
		logic at_max;
	} slot_stat_t;

endpackage

/* rtl/core/lfu_cell.sv */
// lfu_cell: one slot of the replacement table plus its stage of the victim-search chain.
// Applies the broadcast update to its own slot and passes the best candidate onward.
// Depends on lfu_pkg.
module lfu_cell #(
	parameter int unsigned ENTRIES = 16,
	localparam int unsigned IW = $clog2(ENTRIES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IW-1:0]      slot,
	input  lfu_pkg::bcast_t    bc,
	input  logic [IW-1:0]      rank_ref,
	input  logic               tgt_sel,
	input  logic               new_sel,
	input  lfu_pkg::cand_t     cand_in,
	input  logic [IW-1:0]      cand_idx_in,
	input  logic [IW-1:0]      cand_age_in,
	input  logic [IW-1:0]      free_idx_in,
	output lfu_pkg::cand_t     cand_out,
	output logic [IW-1:0]      cand_idx_out,
	output logic [IW-1:0]      cand_age_out,
	output logic [IW-1:0]      free_idx_out,
	output lfu_pkg::slot_stat_t stat,
	output logic [IW-1:0]      rank
);
	import lfu_pkg::*;

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [IW-1:0]         rank_q;

	logic                  best_vld_q;
	logic                  free_found_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [KEY_BITS-1:0]   best_key_q;
	logic [IW-1:0]         best_idx_q;
	logic [IW-1:0]         best_age_q;
	logic [IW-1:0]         free_idx_q;

	logic take_own;

	assign stat.match  = valid_q && (key_q == bc.key);
	assign stat.at_max = (cnt_q == COUNT_MAX);
	assign rank        = rank_q;

	// Lower count wins; on equal counts the older entry into that count wins
	assign take_own = valid_q && (!cand_in.vld || (cnt_q < cand_in.cnt) ||
		((cnt_q == cand_in.cnt) && (rank_q > cand_age_in)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (bc.op)
				UPD_REMOVE: begin
					if (tgt_sel) begin
						valid_q <= 1'b0;
					end
				end
				UPD_INSERT: begin
					if (new_sel) begin
						valid_q <= 1'b1;
					end else if (tgt_sel) begin
						valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (bc.op)
			UPD_RAISE: begin
				if (tgt_sel) begin
					cnt_q  <= cnt_q + 1'b1;
					rank_q <= '0;
				end else if (valid_q && (rank_q < rank_ref)) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			UPD_REMOVE: begin
				if (!tgt_sel && valid_q && (rank_q > rank_ref)) begin
					rank_q <= rank_q - 1'b1;
				end
			end
			UPD_INSERT: begin
				if (new_sel) begin
					key_q  <= bc.key;
					cnt_q  <= COUNT_BITS'(1);
					rank_q <= '0;
				end else if (valid_q && !tgt_sel && !(bc.ev && (rank_q > rank_ref))) begin
					// survivors age by one; those that closed the victim's gap stay put
					rank_q <= rank_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q   <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			best_vld_q   <= cand_in.vld | valid_q;
			free_found_q <= cand_in.free_found | !valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take_own) begin
			best_cnt_q <= cnt_q;
			best_key_q <= key_q;
			best_idx_q <= slot;
			best_age_q <= rank_q;
		end else begin
			best_cnt_q <= cand_in.cnt;
			best_key_q <= cand_in.key;
			best_idx_q <= cand_idx_in;
			best_age_q <= cand_age_in;
		end
		free_idx_q <= cand_in.free_found ? free_idx_in : slot;
	end

	assign cand_out.vld        = best_vld_q;
	assign cand_out.cnt        = best_cnt_q;
	assign cand_out.key        = best_key_q;
	assign cand_out.free_found = free_found_q;
	assign cand_idx_out        = best_idx_q;
	assign cand_age_out        = best_age_q;
	assign free_idx_out        = free_idx_q;

endmodule

/* rtl/core/lfu_page_replacement.sv */
// Least-frequently-used page table over ENTRIES slots, oldest-in-count loses ties.
// An item is taken when start is high and busy is low; its result appears on rsp for
// the single cycle that done is high, and must be captured then. Access, remove and an
// insert of a resident key pass through the match and update states; an insert of a
// new key also passes the scan state between them, while the victim and the first
// free slot ripple one cell per cycle down the chain; busy stays high throughout.
// Capacity (cfg_data) may be written at any time the block is idle.
// Depends on lfu_pkg and lfu_cell.
module lfu_page_replacement #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  lfu_pkg::req_t                  req,
	output logic                           done,
	output lfu_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lfu_pkg::CAP_BITS-1:0]   cfg_data
);
	import lfu_pkg::*;

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned TW = $clog2(ENTRIES + 1);
	localparam int unsigned CW = (TW > CAP_BITS) ? TW : CAP_BITS;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MATCH  = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t                state_q;
	req_t                  req_q;
	logic [ENTRIES-1:0]    match_s1;
	logic                  hit_s1;
	logic [IW-1:0]         scan_cnt_q;
	logic [TW-1:0]         total_q;
	logic [CAP_BITS-1:0]   cap_q;
	rsp_t                  rsp_q;
	logic                  done_q;

	cand_t                 cand     [ENTRIES];
	logic [IW-1:0]         cand_idx [ENTRIES];
	logic [IW-1:0]         cand_age [ENTRIES];
	logic [IW-1:0]         free_idx [ENTRIES];
	slot_stat_t            stat     [ENTRIES];
	logic [IW-1:0]         rank     [ENTRIES];

	logic [ENTRIES-1:0]    match_vec;
	logic [ENTRIES-1:0]    at_max_vec;
	logic [ENTRIES-1:0]    tgt_hot;
	logic [ENTRIES-1:0]    new_hot;
	bcast_t                bc;
	logic [IW-1:0]         rank_ref;

	logic                  is_raise;
	logic                  is_remove;
	logic                  is_ins;
	logic                  do_evict;
	logic                  sat;
	logic [CW-1:0]         cap_ext;
	logic [CW-1:0]         cap_eff;
	logic [CW-1:0]         tot_ext;
	logic [IW-1:0]         free_pick;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		cand_t         c_in;
		logic [IW-1:0] ci_in;
		logic [IW-1:0] ca_in;
		logic [IW-1:0] cf_in;

		if (i == 0) begin : g_head
			assign c_in  = '0;
			assign ci_in = '0;
			assign ca_in = '0;
			assign cf_in = '0;
		end else begin : g_link
			assign c_in  = cand[i-1];
			assign ci_in = cand_idx[i-1];
			assign ca_in = cand_age[i-1];
			assign cf_in = free_idx[i-1];
		end

		lfu_cell #(
			.ENTRIES(ENTRIES)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.slot         (IW'(i)),
			.bc           (bc),
			.rank_ref     (rank_ref),
			.tgt_sel      (tgt_hot[i]),
			.new_sel      (new_hot[i]),
			.cand_in      (c_in),
			.cand_idx_in  (ci_in),
			.cand_age_in  (ca_in),
			.free_idx_in  (cf_in),
			.cand_out     (cand[i]),
			.cand_idx_out (cand_idx[i]),
			.cand_age_out (cand_age[i]),
			.free_idx_out (free_idx[i]),
			.stat         (stat[i]),
			.rank         (rank[i])
		);

		assign match_vec[i]  = stat[i].match;
		assign at_max_vec[i] = stat[i].at_max;
	end

	always_comb begin
		is_raise  = hit_s1 && ((req_q.action == ACT_ACCESS) || (req_q.action == ACT_INSERT));
		is_remove = hit_s1 && (req_q.action == ACT_REMOVE);
		is_ins    = !hit_s1 && (req_q.action == ACT_INSERT);

		// zero counts as one, anything above the table size as the table size
		cap_ext = CW'(cap_q);
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
		tot_ext  = CW'(total_q);
		do_evict = is_ins && (tot_ext >= cap_eff);
		sat      = |(match_s1 & at_max_vec);

		// after an eviction the lowest free slot is the victim or an earlier hole
		if (do_evict && !(cand[ENTRIES-1].free_found &&
				(free_idx[ENTRIES-1] < cand_idx[ENTRIES-1]))) begin
			free_pick = cand_idx[ENTRIES-1];
		end else begin
			free_pick = free_idx[ENTRIES-1];
		end

		rank_ref = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			tgt_hot[i] = (is_raise || is_remove) ? match_s1[i] :
				(do_evict && (cand_idx[ENTRIES-1] == IW'(i)));
			new_hot[i] = is_ins && (free_pick == IW'(i));
			rank_ref   = rank_ref | (tgt_hot[i] ? rank[i] : '0);
		end

		bc.ev  = do_evict;
		bc.key = req_q.page_key;
		if (state_q != ST_UPDATE) begin
			bc.op = UPD_NONE;
		end else if (is_raise && !sat) begin
			bc.op = UPD_RAISE;
		end else if (is_remove) begin
			bc.op = UPD_REMOVE;
		end else if (is_ins) begin
			bc.op = UPD_INSERT;
		end else begin
			bc.op = UPD_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
			total_q    <= '0;
			cap_q      <= CAP_RESET;
			done_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			done_q <= (state_q == ST_UPDATE);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					if ((req_q.action == ACT_INSERT) && !(|match_vec)) begin
						state_q    <= ST_SCAN;
						scan_cnt_q <= '0;
					end else begin
						state_q <= ST_UPDATE;
					end
				end
				ST_SCAN: begin
					// hold until the token has crossed every cell
					if (scan_cnt_q == IW'(ENTRIES - 1)) begin
						state_q <= ST_UPDATE;
					end else begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
					if (bc.op == UPD_REMOVE) begin
						total_q <= total_q - 1'b1;
					end else if ((bc.op == UPD_INSERT) && !do_evict) begin
						total_q <= total_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			req_q <= req;
		end
		if (state_q == ST_MATCH) begin
			match_s1 <= match_vec;
			hit_s1   <= |match_vec;
		end
		if (state_q == ST_UPDATE) begin
			rsp_q.hit          <= hit_s1;
			rsp_q.evicted      <= do_evict;
			rsp_q.victim_key   <= do_evict ? cand[ENTRIES-1].key : '0;
			rsp_q.victim_count <= do_evict ? cand[ENTRIES-1].cnt : '0;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

endmodule

/* rtl/core/lfu_port_chk.sv */
// lfu_port_chk: port-level checks on the LFU page replacement table, bound to the top.
// Watches the command handshake and the result beat only.
// Depends on lfu_pkg and lfu_page_replacement.
module lfu_port_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input lfu_pkg::rsp_t                rsp
);
	import lfu_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.evicted) |-> !rsp.hit)
		else $error("eviction reported on a resident key");

	a_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.evicted) |-> ((rsp.victim_key == '0) && (rsp.victim_count == '0)))
		else $error("victim fields nonzero without eviction");

endmodule

bind lfu_page_replacement lfu_port_chk u_port_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
